// ----- rtl/core/bnt_pkg.sv -----
// shared types, constants and codes for the bounding box normalize and translate block
package bnt_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int AXES        = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MIN_EXT_W  = 31;

  localparam int D2_W    = COORD_WIDTH + 2;
  localparam int MAG_W   = COORD_WIDTH + 1;
  localparam int PROD_W  = MAG_W + COORD_WIDTH;
  localparam int SHIFT   = FRAC_BITS + 1;
  localparam int SCL_W   = PROD_W - SHIFT;
  localparam int SUM_W   = SCL_W + 2;

  localparam int RECIP_QW  = 2 * FRAC_BITS + 1;
  localparam int RECIP_CW  = $clog2(RECIP_QW + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ACCUM = 2'd1,
    MODE_XFORM = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORM_EN = 3'd0,
    REG_TRANS_X = 3'd1,
    REG_TRANS_Y = 3'd2,
    REG_TRANS_Z = 3'd3,
    REG_MIN_EXT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] mode;
    coord_t     point_x;
    coord_t     point_y;
    coord_t     point_z;
    coord_t     world_x;
    coord_t     world_y;
    coord_t     world_z;
  } vertex_t;

  typedef struct packed {
    coord_t out_point_x;
    coord_t out_point_y;
    coord_t out_point_z;
    coord_t out_world_x;
    coord_t out_world_y;
    coord_t out_world_z;
  } result_t;

  typedef struct packed {
    logic                  normalize_enable;
    coord_t [AXES-1:0]     translate;
    logic [MIN_EXT_W-1:0]  min_extent;
  } cfg_t;

  typedef struct packed {
    coord_t [AXES-1:0] pt;
    coord_t [AXES-1:0] wd;
    logic              norm;
  } work_t;

  typedef struct packed {
    coord_t [AXES-1:0]      lo;
    coord_t [AXES-1:0]      hi;
    logic [COORD_WIDTH-1:0] scale;
  } box_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/core/bnt_recip.sv -----
// bit-serial restoring divider for the reciprocal of the largest box extent
module bnt_recip (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [bnt_pkg::COORD_WIDTH-1:0]  divisor,
  output logic                             done,
  output logic [bnt_pkg::COORD_WIDTH-1:0]  quotient
);

  localparam logic [bnt_pkg::RECIP_QW-1:0] NUM_INIT =
    {1'b1, {(bnt_pkg::RECIP_QW-1){1'b0}}};

  logic                              busy;
  logic [bnt_pkg::RECIP_CW-1:0]      cnt;
  logic [bnt_pkg::COORD_WIDTH-1:0]   rem;
  logic [bnt_pkg::RECIP_QW-1:0]      num;
  logic [bnt_pkg::RECIP_QW-1:0]      quo;
  logic [bnt_pkg::COORD_WIDTH:0]     trial;
  logic [bnt_pkg::COORD_WIDTH:0]     diff;
  logic                              ge;

  always_comb begin
    trial = {rem, num[bnt_pkg::RECIP_QW-1]};
    ge    = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= bnt_pkg::RECIP_CW'(bnt_pkg::RECIP_QW);
      end else if (busy) begin
        cnt <= cnt - bnt_pkg::RECIP_CW'(1);
        if (cnt == bnt_pkg::RECIP_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      num <= NUM_INIT;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? diff[bnt_pkg::COORD_WIDTH-1:0] : trial[bnt_pkg::COORD_WIDTH-1:0];
      num <= {num[bnt_pkg::RECIP_QW-2:0], 1'b0};
      quo <= {quo[bnt_pkg::RECIP_QW-2:0], ge};
    end
  end

  assign quotient = (|quo[bnt_pkg::RECIP_QW-1:bnt_pkg::COORD_WIDTH]) ?
                    {bnt_pkg::COORD_WIDTH{1'b1}} : quo[bnt_pkg::COORD_WIDTH-1:0];

endmodule

// ----- rtl/core/bnt_front.sv -----
// front end: input register, bounding box, reciprocal control and item classification
module bnt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  bnt_pkg::vertex_t  vertex,
  input  bnt_pkg::cfg_t     cfg,
  input  bnt_pkg::q_stat_t  q_stat,
  input  logic              back_idle,
  output logic              q_push,
  output bnt_pkg::work_t    q_entry,
  output bnt_pkg::box_t     box
);

  typedef enum logic [1:0] {F_RUN, F_MAX, F_CHK, F_DIV} fstate_t;

  fstate_t                                         state;
  logic                                            in_valid;
  bnt_pkg::vertex_t                                in_item;
  bnt_pkg::coord_t [bnt_pkg::AXES-1:0]             lo;
  bnt_pkg::coord_t [bnt_pkg::AXES-1:0]             hi;
  logic                                            seen;
  logic                                            scale_ready;
  logic [bnt_pkg::COORD_WIDTH-1:0]                 scale_factor;
  logic                                            size_invalid;
  logic [bnt_pkg::AXES-1:0][bnt_pkg::COORD_WIDTH-1:0] diff;
  logic [bnt_pkg::COORD_WIDTH-1:0]                 ext;
  logic [bnt_pkg::COORD_WIDTH-1:0]                 max01;

  bnt_pkg::coord_t [bnt_pkg::AXES-1:0]             pt_v;
  bnt_pkg::coord_t [bnt_pkg::AXES-1:0]             wd_v;
  logic                                            consume;
  logic                                            start_scale;
  logic                                            bad;
  logic                                            div_start;
  logic                                            div_done;
  logic [bnt_pkg::COORD_WIDTH-1:0]                 div_q;

  assign pt_v = {in_item.point_z, in_item.point_y, in_item.point_x};
  assign wd_v = {in_item.world_z, in_item.world_y, in_item.world_x};

  always_comb begin
    consume     = 1'b0;
    q_push      = 1'b0;
    start_scale = 1'b0;
    if (state == F_RUN && in_valid) begin
      unique case (in_item.mode)
        bnt_pkg::MODE_CLEAR: consume = back_idle;
        bnt_pkg::MODE_ACCUM: consume = back_idle;
        bnt_pkg::MODE_XFORM: begin
          if (!cfg.normalize_enable) begin
            consume = !q_stat.full;
            q_push  = !q_stat.full;
          end else if (!scale_ready) begin
            start_scale = back_idle;
          end else if (size_invalid) begin
            consume = 1'b1;
          end else begin
            consume = !q_stat.full;
            q_push  = !q_stat.full;
          end
        end
        default: consume = 1'b1;
      endcase
    end
  end

  assign full = in_valid && !consume;

  assign max01 = (diff[0] > diff[1]) ? diff[0] : diff[1];
  assign bad   = !seen || (ext == '0) || (ext < {1'b0, cfg.min_extent});
  assign div_start = (state == F_CHK) && !bad;

  bnt_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (ext),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_RUN;
      in_valid     <= 1'b0;
      lo           <= {bnt_pkg::AXES{bnt_pkg::COORD_MAX}};
      hi           <= {bnt_pkg::AXES{bnt_pkg::COORD_MIN}};
      seen         <= 1'b0;
      scale_ready  <= 1'b0;
      scale_factor <= '0;
      size_invalid <= 1'b0;
    end else begin
      if (push && !full) begin
        in_valid <= 1'b1;
        in_item  <= vertex;
      end else if (consume) begin
        in_valid <= 1'b0;
      end
      unique case (state)
        F_RUN: begin
          if (consume && in_item.mode == bnt_pkg::MODE_CLEAR) begin
            lo           <= {bnt_pkg::AXES{bnt_pkg::COORD_MAX}};
            hi           <= {bnt_pkg::AXES{bnt_pkg::COORD_MIN}};
            seen         <= 1'b0;
            scale_ready  <= 1'b0;
            size_invalid <= 1'b0;
          end else if (consume && in_item.mode == bnt_pkg::MODE_ACCUM) begin
            for (int a = 0; a < bnt_pkg::AXES; a++) begin
              if ($signed(pt_v[a]) < $signed(lo[a])) lo[a] <= pt_v[a];
              if ($signed(pt_v[a]) > $signed(hi[a])) hi[a] <= pt_v[a];
            end
            seen        <= 1'b1;
            scale_ready <= 1'b0;
          end
          if (start_scale) begin
            for (int a = 0; a < bnt_pkg::AXES; a++) begin
              diff[a] <= hi[a] - lo[a];
            end
            state <= F_MAX;
          end
        end
        F_MAX: begin
          ext   <= (max01 > diff[2]) ? max01 : diff[2];
          state <= F_CHK;
        end
        F_CHK: begin
          if (bad) begin
            size_invalid <= 1'b1;
            scale_ready  <= 1'b1;
            state        <= F_RUN;
          end else begin
            state <= F_DIV;
          end
        end
        F_DIV: begin
          if (div_done) begin
            scale_factor <= div_q;
            scale_ready  <= 1'b1;
            size_invalid <= 1'b0;
            state        <= F_RUN;
          end
        end
        default: state <= F_RUN;
      endcase
    end
  end

  assign q_entry.pt   = pt_v;
  assign q_entry.wd   = wd_v;
  assign q_entry.norm = cfg.normalize_enable;

  assign box.lo    = lo;
  assign box.hi    = hi;
  assign box.scale = scale_factor;

  a_push_scaled: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (!cfg.normalize_enable || (scale_ready && !size_invalid)))
    else $error("item queued without a valid scale");

  a_box_idle: assert property (@(posedge clk) disable iff (rst)
    (!$stable(lo) || !$stable(hi)) |-> $past(back_idle))
    else $error("bounding box changed while back end busy");

endmodule

// ----- rtl/core/bnt_queue.sv -----
// short work queue between front and back ends
module bnt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bnt_pkg::work_t    entry,
  input  logic              pop,
  output bnt_pkg::work_t    head,
  output bnt_pkg::q_stat_t  stat
);

  bnt_pkg::work_t                  mem [bnt_pkg::QUEUE_DEPTH];
  logic [bnt_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [bnt_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [bnt_pkg::QUEUE_CW-1:0]    cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + bnt_pkg::QUEUE_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + bnt_pkg::QUEUE_AW'(1);
      cnt <= cnt + bnt_pkg::QUEUE_CW'(push) - bnt_pkg::QUEUE_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= entry;
  end

  assign head       = mem[rd_ptr];
  assign stat.full  = cnt == bnt_pkg::QUEUE_CW'(bnt_pkg::QUEUE_DEPTH);
  assign stat.empty = cnt == '0;

endmodule

// ----- rtl/core/bnt_back.sv -----
// back end: centre, scale, translate and saturate pipeline with result queue
module bnt_back (
  input  logic              clk,
  input  logic              rst,
  input  bnt_pkg::cfg_t     cfg,
  input  bnt_pkg::box_t     box,
  input  bnt_pkg::work_t    head,
  input  bnt_pkg::q_stat_t  q_stat,
  output logic              q_pop,
  output logic              back_idle,
  output logic              empty,
  input  logic              pop,
  output bnt_pkg::result_t  result
);

  typedef logic signed [bnt_pkg::D2_W-1:0]  d2_t;
  typedef logic [bnt_pkg::MAG_W-1:0]        mag_t;
  typedef logic [bnt_pkg::PROD_W-1:0]       prod_t;
  typedef logic signed [bnt_pkg::SUM_W-1:0] sum_t;

  logic                                  pass;
  logic                                  issue0;
  logic                                  issue;
  logic [bnt_pkg::OUT_CW-1:0]            reserved;
  bnt_pkg::coord_t [bnt_pkg::AXES-1:0]   vsel;

  logic                                  v1, v2, v3;
  logic                                  pass1, pass2, pass3;
  logic                                  norm1, norm2, norm3;
  bnt_pkg::coord_t [bnt_pkg::AXES-1:0]   raw1, raw2, raw3;
  d2_t [bnt_pkg::AXES-1:0]               d2_1;
  logic [bnt_pkg::AXES-1:0]              neg2, neg3;
  mag_t [bnt_pkg::AXES-1:0]              mag2;
  prod_t [bnt_pkg::AXES-1:0]             prod3;

  bnt_pkg::coord_t [bnt_pkg::AXES-1:0]   res;
  bnt_pkg::coord_t [bnt_pkg::AXES-1:0]   pt_hold;

  bnt_pkg::result_t                      mem [bnt_pkg::OUT_DEPTH];
  logic [bnt_pkg::OUT_AW-1:0]            wr_ptr;
  logic [bnt_pkg::OUT_AW-1:0]            rd_ptr;
  logic [bnt_pkg::OUT_CW-1:0]            ocnt;
  logic                                  fifo_wr;
  logic                                  fifo_rd;

  assign issue0 = !pass && !q_stat.empty &&
                  (reserved < bnt_pkg::OUT_CW'(bnt_pkg::OUT_DEPTH));
  assign issue  = issue0 || pass;
  assign q_pop  = pass;
  assign vsel   = pass ? head.wd : head.pt;

  assign back_idle = q_stat.empty && !pass && !v1 && !v2 && !v3;

  assign fifo_wr = v3 && pass3;
  assign fifo_rd = pop && !empty;
  assign empty   = ocnt == '0;
  assign result  = mem[rd_ptr];

  // final stage: translate and saturate
  always_comb begin
    logic [bnt_pkg::SCL_W-1:0] scaled;
    sum_t t;
    sum_t opb;
    sum_t sum;
    for (int a = 0; a < bnt_pkg::AXES; a++) begin
      scaled = prod3[a][bnt_pkg::PROD_W-1:bnt_pkg::SHIFT];
      t      = {{(bnt_pkg::SUM_W-bnt_pkg::COORD_WIDTH){cfg.translate[a][bnt_pkg::COORD_WIDTH-1]}},
                cfg.translate[a]};
      opb    = norm3 ? {2'b00, scaled} :
               {{(bnt_pkg::SUM_W-bnt_pkg::COORD_WIDTH){raw3[a][bnt_pkg::COORD_WIDTH-1]}}, raw3[a]};
      sum    = (norm3 && neg3[a]) ? t - opb : t + opb;
      if (&sum[bnt_pkg::SUM_W-1:bnt_pkg::COORD_WIDTH-1] ||
          ~|sum[bnt_pkg::SUM_W-1:bnt_pkg::COORD_WIDTH-1]) begin
        res[a] = sum[bnt_pkg::COORD_WIDTH-1:0];
      end else if (sum[bnt_pkg::SUM_W-1]) begin
        res[a] = bnt_pkg::COORD_MIN;
      end else begin
        res[a] = bnt_pkg::COORD_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass     <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      reserved <= '0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      ocnt     <= '0;
    end else begin
      pass     <= issue0;
      v1       <= issue;
      v2       <= v1;
      v3       <= v2;
      reserved <= reserved + bnt_pkg::OUT_CW'(issue0) - bnt_pkg::OUT_CW'(fifo_rd);
      if (fifo_wr) wr_ptr <= wr_ptr + bnt_pkg::OUT_AW'(1);
      if (fifo_rd) rd_ptr <= rd_ptr + bnt_pkg::OUT_AW'(1);
      ocnt <= ocnt + bnt_pkg::OUT_CW'(fifo_wr) - bnt_pkg::OUT_CW'(fifo_rd);
    end
  end

  always_ff @(posedge clk) begin
    pass1 <= pass;
    norm1 <= head.norm;
    raw1  <= vsel;
    for (int a = 0; a < bnt_pkg::AXES; a++) begin
      d2_1[a] <= {vsel[a][bnt_pkg::COORD_WIDTH-1], vsel[a], 1'b0}
                 - {{2{box.lo[a][bnt_pkg::COORD_WIDTH-1]}}, box.lo[a]}
                 - {{2{box.hi[a][bnt_pkg::COORD_WIDTH-1]}}, box.hi[a]};
    end

    pass2 <= pass1;
    norm2 <= norm1;
    raw2  <= raw1;
    for (int a = 0; a < bnt_pkg::AXES; a++) begin
      neg2[a] <= d2_1[a][bnt_pkg::D2_W-1];
      mag2[a] <= d2_1[a][bnt_pkg::D2_W-1] ? mag_t'(-d2_1[a]) : mag_t'(d2_1[a]);
    end

    pass3 <= pass2;
    norm3 <= norm2;
    raw3  <= raw2;
    neg3  <= neg2;
    for (int a = 0; a < bnt_pkg::AXES; a++) begin
      prod3[a] <= prod_t'(mag2[a]) * prod_t'(box.scale);
    end

    if (v3 && !pass3) pt_hold <= res;
    if (fifo_wr) begin
      mem[wr_ptr] <= '{out_point_x: pt_hold[0], out_point_y: pt_hold[1],
                       out_point_z: pt_hold[2], out_world_x: res[0],
                       out_world_y: res[1], out_world_z: res[2]};
    end
  end

  a_credit: assert property (@(posedge clk) disable iff (rst)
    reserved <= bnt_pkg::OUT_CW'(bnt_pkg::OUT_DEPTH) && ocnt <= reserved)
    else $error("result credits out of range");

  a_world_follows: assert property (@(posedge clk) disable iff (rst)
    issue0 |=> (pass && !q_stat.empty))
    else $error("world pass issued without its queue entry");

  a_fifo_room: assert property (@(posedge clk) disable iff (rst)
    fifo_wr |-> ocnt != bnt_pkg::OUT_CW'(bnt_pkg::OUT_DEPTH))
    else $error("result written into a full queue");

endmodule

// ----- rtl/core/bbox_normalize_translate.sv -----
// top level of the bounding box normalize and translate block
// A clear or accumulate item waits until every transform already taken has left the
// arithmetic pipeline, since those still read the box. A transform item occupies the
// back end for a point vector pass, then a world vector pass, through three per-axis
// 33x32 multipliers. A new transform can enter behind it while earlier ones are still
// in the pipeline, as long as the result queue has room. The first normalized
// transform after a clear or accumulate waits while the reciprocal of the largest
// extent is formed one quotient bit per cycle (33 bits).
// Results queue four deep; a transform that is dropped for an empty or too small box
// gives nothing on the result side.
module bbox_normalize_translate (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  bnt_pkg::vertex_t                   vertex,
  output logic                               empty,
  input  logic                               pop,
  output bnt_pkg::result_t                   result,
  input  logic                               cfg_we,
  input  logic [bnt_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [bnt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  bnt_pkg::cfg_t     cfg;
  bnt_pkg::q_stat_t  q_stat;
  bnt_pkg::work_t    q_entry;
  bnt_pkg::work_t    q_head;
  bnt_pkg::box_t     box;
  logic              q_push;
  logic              q_pop;
  logic              back_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normalize_enable <= 1'b1;
      cfg.translate        <= '0;
      cfg.min_extent       <= bnt_pkg::MIN_EXT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bnt_pkg::REG_NORM_EN: cfg.normalize_enable <= cfg_wdata[0];
        bnt_pkg::REG_TRANS_X: cfg.translate[0] <= cfg_wdata[bnt_pkg::COORD_WIDTH-1:0];
        bnt_pkg::REG_TRANS_Y: cfg.translate[1] <= cfg_wdata[bnt_pkg::COORD_WIDTH-1:0];
        bnt_pkg::REG_TRANS_Z: cfg.translate[2] <= cfg_wdata[bnt_pkg::COORD_WIDTH-1:0];
        bnt_pkg::REG_MIN_EXT: cfg.min_extent <= cfg_wdata[bnt_pkg::MIN_EXT_W-1:0];
        default: ;
      endcase
    end
  end

  bnt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .vertex    (vertex),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .back_idle (back_idle),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .box       (box)
  );

  bnt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .entry (q_entry),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  bnt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .box       (box),
    .head      (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .back_idle (back_idle),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
